// ----- rtl/core/rd3_pkg.sv -----
// ----------------------------------------------------------------------------
// rd3_pkg: shared types and constants for the rounded 3D distance block
// Coordinate, square, sum and root widths, plus the root pipeline word.
// ----------------------------------------------------------------------------
`default_nettype none

package rd3_pkg;

  localparam int unsigned CoordW  = 30;              // signed coordinate
  localparam int unsigned MagW    = CoordW;          // |a - b| < 2^30
  localparam int unsigned SqW     = 2 * MagW;        // one squared difference
  localparam int unsigned SumW    = SqW + 2;         // sum of three squares
  localparam int unsigned RadW    = SumW + 2;        // 4 * sum, 64 bits
  localparam int unsigned RootW   = RadW / 2;        // floor root, 32 bits
  localparam int unsigned DistW   = 31;              // rounded distance
  localparam int unsigned NumLanes = 3;              // x, y, z
  localparam int unsigned NumSteps = RadW / 2;       // one root bit per step

  localparam int unsigned InDataW  = 184;            // 6 x 30 bits, byte padded
  localparam int unsigned OutDataW = 32;             // 31 bits, byte padded

  // Running state of the digit-by-digit root.
  typedef struct packed {
    logic [RadW-1:0] rem;    // radicand minus squared partial root
    logic [RadW-1:0] root;   // partial root, pre-shifted form
  } rd3_root_t;

endpackage

`default_nettype wire

// ----- rtl/core/rd3_lane.sv -----
// ----------------------------------------------------------------------------
// rd3_lane: one axis lane
// Registers |a - b|, then registers its square. Takes one item a cycle while en_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rd3_lane
  import rd3_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [CoordW-1:0] a_i,
  input  wire logic signed [CoordW-1:0] b_i,
  output logic             [SqW-1:0]    sq_o
);

  logic signed [CoordW:0] diff;
  logic [MagW-1:0] mag_d, mag_q;
  logic [SqW-1:0]  sq_d, sq_q;

  // |a - b| < 2^30, so the magnitude fits in MagW bits
  always_comb begin
    diff  = $signed({a_i[CoordW-1], a_i}) - $signed({b_i[CoordW-1], b_i});
    mag_d = diff[CoordW] ? MagW'(-diff) : MagW'(diff);
    sq_d  = SqW'(mag_q) * SqW'(mag_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      sq_q  <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ----- rtl/core/rd3_root_step.sv -----
// ----------------------------------------------------------------------------
// rd3_root_step: one registered step of the restoring square root
// Trial-subtracts (root | bit) from the remainder and updates the root.
// ----------------------------------------------------------------------------
`default_nettype none

module rd3_root_step
  import rd3_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [RadW-1:0] bit_i,    // constant per step
  input  wire rd3_root_t       st_i,
  output logic                 valid_o,
  output rd3_root_t            st_o
);

  logic            valid_q;
  rd3_root_t       st_d, st_q;
  logic [RadW-1:0] trial;

  // root and bit never overlap, so the add is an OR
  always_comb begin
    trial = st_i.root | bit_i;
    if (st_i.rem >= trial) begin
      st_d.rem  = st_i.rem - trial;
      st_d.root = (st_i.root >> 1) | bit_i;
    end else begin
      st_d.rem  = st_i.rem;
      st_d.root = st_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

`default_nettype wire

// ----- rtl/core/rounded_distance_3d_top.sv -----
// ----------------------------------------------------------------------------
// rounded_distance_3d_top: rounded Euclidean distance of two 3D points
// Three axis lanes, a merging adder, a 32-step root pipeline and rounding.
// ----------------------------------------------------------------------------
// Takes one pair of points per item and returns round(sqrt(dx^2+dy^2+dz^2)).
// Coordinates are 30-bit two's complement. Throughput is one item per cycle
// while the master side does not stall. An item passes the axis lanes
// (difference magnitude, then square), the merging adder, the root pipeline
// (one root bit per stage, each a 64-bit compare and subtract) and the output
// register, which takes the rounded root. The whole pipeline moves as one: it
// advances when the output register is empty or being taken, so a stall on
// the master side holds every stage and deasserts s_axis_tready_o. Rounding
// uses (floor(sqrt(4*S)) + 1) / 2, which is exact round-to-nearest for
// integer S.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_distance_3d_top
  import rd3_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // ax[29:0], ay[59:30], az[89:60], bx[119:90], by[149:120], bz[179:150],
  // zero [183:180]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // distance[30:0], zero [31]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  // global advance: output slot free or being drained
  logic adv;
  logic out_valid_q;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---- axis lanes ----------------------------------------------------------
  logic [SqW-1:0] lane_sq [NumLanes];
  logic           v1_q, v2_q;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rd3_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (s_axis_tdata_i[l*CoordW +: CoordW]),
      .b_i   (s_axis_tdata_i[(l+NumLanes)*CoordW +: CoordW]),
      .sq_o  (lane_sq[l])
    );
  end

  // ---- merge: sum of squares ----------------------------------------------
  logic [SumW-1:0] sum_d, sum_q;
  logic            v3_q;

  assign sum_d = SumW'(lane_sq[0]) + SumW'(lane_sq[1]) + SumW'(lane_sq[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sum_d;
    end
  end

  // ---- root pipeline on 4*S -------------------------------------------------
  rd3_root_t st    [NumSteps+1];
  logic      st_v  [NumSteps+1];

  assign st[0].rem  = {sum_q, 2'b00};
  assign st[0].root = '0;
  assign st_v[0]    = v3_q;

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    localparam logic [RadW-1:0] StepBit = RadW'(1) << (RadW - 2 - 2*k);
    rd3_root_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (st_v[k]),
      .bit_i   (StepBit),
      .st_i    (st[k]),
      .valid_o (st_v[k+1]),
      .st_o    (st[k+1])
    );
  end

  // ---- rounding and output register ---------------------------------------
  logic [RootW:0]   rnd;
  logic [DistW-1:0] dist_q;

  assign rnd = (RootW+1)'(st[NumSteps].root[RootW-1:0]) + (RootW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_v[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= rnd[DistW:1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, dist_q};

`ifndef SYNTHESIS
  // final remainder is bounded by twice the root (exact floor root)
  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v[NumSteps] |-> (st[NumSteps].rem <= {st[NumSteps].root[RadW-2:0], 1'b0}))
    else $error("root remainder out of range");

  // root fits in 32 bits
  a_root_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v[NumSteps] |-> (st[NumSteps].root[RadW-1:RootW] == '0))
    else $error("root wider than 32 bits");

  // result within the reachable range
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (dist_q <= DistW'(1859775393)))
    else $error("distance out of range");

  // an accepted item enters the first lane stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted item lost at lane entry");
`endif

endmodule

`default_nettype wire
